// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

    // Default widths and depths
    localparam int SIZE_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Byte classes produced by the front end
    localparam logic [2:0] CLS_HEX   = 3'd0;
    localparam logic [2:0] CLS_SEMI  = 3'd1;
    localparam logic [2:0] CLS_CR    = 3'd2;
    localparam logic [2:0] CLS_LF    = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    // Special characters
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

    // One classified word in the queue
    typedef struct packed {
        logic       restart;
        logic [2:0] cls;
        logic [3:0] hex_val;
        logic [7:0] data;
    } t_token;

endpackage

// ===== design/hcbd_classify.sv =====
module hcbd_classify (
    input  logic [7:0]      i_byte,
    input  logic            i_restart,
    output hcbd_pkg::t_token o_token
);
    import hcbd_pkg::*;

    logic is_digit;
    logic is_letter;

    // Hex digit detection; letters map through their low nibble plus nine
    assign is_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign is_letter = ((i_byte >= CH_LO_A) && (i_byte <= CH_LO_F)) ||
                       ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_F));

    always_comb begin
        o_token.restart = i_restart;
        o_token.data    = i_byte;
        o_token.hex_val = is_digit ? i_byte[3:0] : i_byte[3:0] + HEX_LETTER_OFS;
        if (is_digit || is_letter) begin
            o_token.cls = CLS_HEX;
        end else if (i_byte == CH_SEMI) begin
            o_token.cls = CLS_SEMI;
        end else if (i_byte == CH_CR) begin
            o_token.cls = CLS_CR;
        end else if (i_byte == CH_LF) begin
            o_token.cls = CLS_LF;
        end else begin
            o_token.cls = CLS_OTHER;
        end
    end

endmodule

// ===== design/hcbd_queue.sv =====
module hcbd_queue #(
    parameter int DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hcbd_pkg::t_token i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output hcbd_pkg::t_token o_data
);
    import hcbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/hcbd_engine.sv =====
module hcbd_engine #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hcbd_pkg::t_token i_token,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic [1:0]       o_kind
);
    import hcbd_pkg::*;

    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_EXT     = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_DATA_CR = 3'd3;
    localparam logic [2:0] PH_DATA_LF = 3'd4;
    localparam logic [2:0] PH_TRAILER = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_BAD     = 3'd7;

    logic [2:0]           r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [SIZE_BITS-1:0] r_left, n_left;
    logic [SIZE_BITS-1:0] left_dec;
    logic                 r_digit, n_digit;
    logic                 r_nonempty, n_nonempty;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte, n_out_byte;
    logic [1:0]           r_out_kind, n_out_kind;
    logic                 advance;

    // Output register frees up when empty or being taken
    assign o_ready  = !r_out_valid || i_ready;
    assign advance  = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_kind   = r_out_kind;
    assign left_dec = r_left - 1'b1;

    // Per-word state update
    always_comb begin
        n_phase    = r_phase;
        n_size     = r_size;
        n_left     = r_left;
        n_digit    = r_digit;
        n_nonempty = r_nonempty;
        n_out_byte = 8'd0;
        n_out_kind = KIND_FRAME;
        if (i_token.restart) begin
            n_phase    = PH_SIZE;
            n_size     = '0;
            n_left     = '0;
            n_digit    = 1'b0;
            n_nonempty = 1'b0;
        end else begin
            unique case (r_phase)
                PH_SIZE, PH_EXT: begin
                    if (r_phase == PH_SIZE && i_token.cls == CLS_HEX) begin
                        if (r_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                            n_phase    = PH_BAD;
                            n_out_kind = KIND_BAD;
                        end else begin
                            n_size  = {r_size[SIZE_BITS-5:0], i_token.hex_val};
                            n_digit = 1'b1;
                        end
                    end else if (i_token.cls == CLS_LF) begin
                        // end of size line
                        if (!r_digit) begin
                            n_phase    = PH_BAD;
                            n_out_kind = KIND_BAD;
                        end else begin
                            if (r_size == '0) begin
                                n_phase    = PH_TRAILER;
                                n_nonempty = 1'b0;
                            end else begin
                                n_left  = r_size;
                                n_phase = PH_DATA;
                            end
                            n_size  = '0;
                            n_digit = 1'b0;
                        end
                    end else if (r_phase == PH_SIZE) begin
                        if (i_token.cls == CLS_SEMI) begin
                            n_phase = PH_EXT;
                        end else if (i_token.cls != CLS_CR) begin
                            n_phase    = PH_BAD;
                            n_out_kind = KIND_BAD;
                        end
                    end
                end
                PH_DATA: begin
                    n_out_kind = KIND_PAYLOAD;
                    n_out_byte = i_token.data;
                    n_left     = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (i_token.cls == CLS_LF) begin
                        n_phase = PH_SIZE;
                    end else if (i_token.cls == CLS_CR) begin
                        n_phase = PH_DATA_LF;
                    end else begin
                        n_phase    = PH_BAD;
                        n_out_kind = KIND_BAD;
                    end
                end
                PH_DATA_LF: begin
                    if (i_token.cls == CLS_LF) begin
                        n_phase = PH_SIZE;
                    end else begin
                        n_phase    = PH_BAD;
                        n_out_kind = KIND_BAD;
                    end
                end
                PH_TRAILER: begin
                    if (i_token.cls == CLS_LF) begin
                        if (!r_nonempty) begin
                            n_phase    = PH_DONE;
                            n_out_kind = KIND_DONE;
                        end
                        n_nonempty = 1'b0;
                    end else if (i_token.cls != CLS_CR) begin
                        n_nonempty = 1'b1;
                    end
                end
                PH_DONE: begin
                    n_out_kind = KIND_DONE;
                end
                default: begin
                    n_phase    = PH_BAD;
                    n_out_kind = KIND_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_size      <= '0;
            r_left      <= '0;
            r_digit     <= 1'b0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase    <= n_phase;
                r_size     <= n_size;
                r_left     <= n_left;
                r_digit    <= n_digit;
                r_nonempty <= n_nonempty;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_kind <= n_out_kind;
        end
    end

endmodule

// ===== design/http_chunked_body_decoder_unit.sv =====
// Chunked body decoder: one raw body byte in, one classified word out.
// Slave channel s_axis: tdata carries the byte, tuser the restart flag
// (restart clears the decoder to the size line; its byte is ignored).
// Master channel m_axis: tdata carries the payload byte (zero unless the
// kind is payload), tuser the kind: framing, payload, body done, malformed.
// Errors and size overflow stick as malformed until a restart word.
// A word accepted on s_axis goes into a queue slot, then through the
// registered decoder step, which puts its result on m_axis.
// Throughput: one word per cycle while m_axis_tready is high; the decoder
// update is one combinational step (hex accumulate, down-count, compare).
// A two-word queue between the byte classifier and the decoder takes up
// stalls: while m_axis_tready is low the result holds, the queue fills and
// s_axis_tready drops once it is full.
// Reset (i_rst_n low, synchronous) empties the queue and the output
// register and returns the decoder to the size-line state.
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS   = hcbd_pkg::SIZE_BITS_DEF,
    parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] byte_in
    input  logic [0:0] s_axis_tuser,  // [0] restart
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] byte_out
    output logic [1:0] m_axis_tuser   // [1:0] kind
);
    import hcbd_pkg::*;

    t_token in_token;
    t_token q_token;
    logic   q_valid;
    logic   q_ready;

    // Front: classify the incoming byte
    hcbd_classify u_classify (
        .i_byte    (s_axis_tdata),
        .i_restart (s_axis_tuser[0]),
        .o_token   (in_token)
    );

    // Decoupling queue
    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (in_token),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_token)
    );

    // Back: framing state machine with output register
    hcbd_engine #(
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_token (q_token),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_kind  (m_axis_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import hcbd_pkg::*;

    localparam int SIZE_BITS   = SIZE_BITS_DEF;
    localparam int RAND_WORDS  = 1750;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_EVERY = 400;

    // Decoder phases of the predictor
    typedef enum logic [2:0] {
        ST_SIZE,
        ST_EXT,
        ST_DATA,
        ST_DATA_CR,
        ST_DATA_LF,
        ST_TRAILER,
        ST_DONE,
        ST_BAD
    } chunk_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } chunk_result_t;

    // Predicts the decoder's answer to each accepted word and checks the outputs
    class chunk_scoreboard;
        chunk_phase_e         phase;
        logic [SIZE_BITS-1:0] size_accum;
        logic [SIZE_BITS-1:0] bytes_left;
        logic                 digit_seen;
        logic                 trailer_nonempty;
        chunk_result_t        expected_q[$];
        int                   errors;
        int                   words_in;
        int                   restarts;
        int                   kind_cnt[4];

        function new();
            clear();
            errors   = 0;
            words_in = 0;
            restarts = 0;
            foreach (kind_cnt[i]) kind_cnt[i] = 0;
        endfunction

        function void clear();
            phase            = ST_SIZE;
            size_accum       = '0;
            bytes_left       = '0;
            digit_seen       = 1'b0;
            trailer_nonempty = 1'b0;
        endfunction

        function int hex_value(logic [7:0] b);
            if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
            if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
            if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
            return -1;
        endfunction

        // LF that closes a size line (or its extension)
        function logic [1:0] close_size_line();
            if (!digit_seen) begin
                phase = ST_BAD;
                return KIND_BAD;
            end
            if (size_accum == '0) begin
                phase            = ST_TRAILER;
                trailer_nonempty = 1'b0;
            end else begin
                bytes_left = size_accum;
                phase      = ST_DATA;
            end
            size_accum = '0;
            digit_seen = 1'b0;
            return KIND_FRAME;
        endfunction

        function void note_input(logic [7:0] b, logic rst);
            chunk_result_t res;
            int            hv;
            res.data = 8'h00;
            res.kind = KIND_FRAME;
            words_in++;
            if (rst) begin
                restarts++;
                clear();
            end else begin
                case (phase)
                    ST_SIZE: begin
                        hv = hex_value(b);
                        if (hv >= 0) begin
                            // refuse a digit that would shift bits out of the size
                            if ((size_accum >> (SIZE_BITS - 4)) != '0) begin
                                phase    = ST_BAD;
                                res.kind = KIND_BAD;
                            end else begin
                                size_accum = (size_accum << 4) | SIZE_BITS'(hv);
                                digit_seen = 1'b1;
                            end
                        end else if (b == CH_SEMI) begin
                            phase = ST_EXT;
                        end else if (b == CH_CR) begin
                            // skipped
                        end else if (b == CH_LF) begin
                            res.kind = close_size_line();
                        end else begin
                            phase    = ST_BAD;
                            res.kind = KIND_BAD;
                        end
                    end
                    ST_EXT: begin
                        if (b == CH_LF) res.kind = close_size_line();
                    end
                    ST_DATA: begin
                        res.kind   = KIND_PAYLOAD;
                        res.data   = b;
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == '0) phase = ST_DATA_CR;
                    end
                    ST_DATA_CR: begin
                        if (b == CH_LF) begin
                            phase = ST_SIZE;
                        end else if (b == CH_CR) begin
                            phase = ST_DATA_LF;
                        end else begin
                            phase    = ST_BAD;
                            res.kind = KIND_BAD;
                        end
                    end
                    ST_DATA_LF: begin
                        if (b == CH_LF) begin
                            phase = ST_SIZE;
                        end else begin
                            phase    = ST_BAD;
                            res.kind = KIND_BAD;
                        end
                    end
                    ST_TRAILER: begin
                        if (b == CH_LF) begin
                            if (!trailer_nonempty) begin
                                phase    = ST_DONE;
                                res.kind = KIND_DONE;
                            end
                            trailer_nonempty = 1'b0;
                        end else if (b != CH_CR) begin
                            trailer_nonempty = 1'b1;
                        end
                    end
                    ST_DONE: begin
                        res.kind = KIND_DONE;
                    end
                    default: begin
                        phase    = ST_BAD;
                        res.kind = KIND_BAD;
                    end
                endcase
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] kind);
            chunk_result_t exp;
            if (expected_q.size() == 0) begin
                $display("%t: unexpected word data=%h kind=%0d", $realtime, data, kind);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            kind_cnt[exp.kind]++;
            if (kind !== exp.kind) begin
                $display("%t: kind mismatch: expected %0d, actual %0d",
                         $realtime, exp.kind, kind);
                errors++;
            end
            if (data !== exp.data) begin
                $display("%t: data mismatch: expected %h, actual %h",
                         $realtime, exp.data, data);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_in
    logic [0:0] s_axis_tuser;   // [0] restart
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] byte_out
    logic [1:0] m_axis_tuser;   // [1:0] kind

    chunk_scoreboard sb = new();
    logic [7:0]      body_q[$];
    bit              burst_mode = 1'b0;
    int              words_sent = 0;
    int              bodies     = 0;
    int              idle_cycles = 0;

    http_chunked_body_decoder_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver backpressure
    initial begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst_mode) begin
                hold = 0;
                m_axis_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (!m_axis_tready) begin
                m_axis_tready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    m_axis_tready <= 1'b0;
                    hold--;
                end
            end
        end
    end

    // Present one word from a falling edge and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic rst);
        int n;
        n = burst_mode ? 0 : pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(b, rst);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] hex_char(int d);
        if (d < 10) return CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] rand_byte_not(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
        return v;
    endfunction

    // Size line: optional leading zeros, stray CRs, extension, CRLF or LF
    function automatic void add_size_line(int unsigned size);
        int digits[$];
        int unsigned s;
        int zeros;
        int ext_len;
        s = size;
        do begin
            digits.push_front(s % 16);
            s = s / 16;
        end while (s != 0);
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (zeros) digits.push_front(0);
        foreach (digits[i]) begin
            body_q.push_back(hex_char(digits[i]));
            if ($urandom_range(0, 9) == 0) body_q.push_back(CH_CR);
        end
        if ($urandom_range(0, 3) == 0) begin
            body_q.push_back(CH_SEMI);
            ext_len = $urandom_range(0, 5);
            repeat (ext_len) body_q.push_back(rand_byte_not(CH_LF, CH_LF));
        end
        if ($urandom_range(0, 1)) body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
    endfunction

    // One well-formed chunked body with random content
    function automatic void add_body();
        int chunks;
        int unsigned size;
        int lines;
        int len;
        chunks = $urandom_range(0, 4);
        repeat (chunks) begin
            size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            add_size_line(size);
            repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) body_q.push_back(CH_CR);
            body_q.push_back(CH_LF);
        end
        add_size_line(0);
        lines = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lines) begin
            len = $urandom_range(1, 6);
            repeat (len) body_q.push_back(rand_byte_not(CH_CR, CH_LF));
            if ($urandom_range(0, 1)) body_q.push_back(CH_CR);
            body_q.push_back(CH_LF);
        end
        if ($urandom_range(0, 1)) body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
        len = $urandom_range(0, 2);
        repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Size line too long for the size register
    function automatic void add_oversize();
        int extra;
        body_q.push_back(hex_char($urandom_range(1, 15)));
        extra = $urandom_range(SIZE_BITS / 4, SIZE_BITS / 4 + 3);
        repeat (extra) body_q.push_back(hex_char($urandom_range(0, 15)));
        body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Restart, then the queued bytes, with an occasional restart mid-stream
    task automatic send_body();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        foreach (body_q[i]) begin
            if ($urandom_range(0, 299) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
            send_word(body_q[i], 1'b0);
        end
        body_q.delete();
        bodies++;
    endtask

    initial begin
        logic [8:0] directed_words[$];
        int         directed_total;
        int         next_drain;
        int         pick;
        int         idx;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;

        // Directed: extension, payload extremes, bare LF, trailer end, done,
        // empty size line, sticky malformed, size overflow
        directed_words = '{
            {1'b1, 8'hFF},
            {1'b0, "2"}, {1'b0, CH_SEMI}, {1'b0, "e"}, {1'b0, CH_CR}, {1'b0, CH_LF},
            {1'b0, 8'h00}, {1'b0, 8'hFF},
            {1'b0, CH_LF},
            {1'b0, "0"}, {1'b0, CH_CR}, {1'b0, CH_LF},
            {1'b0, CH_CR}, {1'b0, CH_LF},
            {1'b0, 8'h55},
            {1'b1, 8'h00},
            {1'b0, CH_LF},
            {1'b0, 8'hA5},
            {1'b1, 8'h5A},
            {1'b0, "f"}, {1'b0, "F"}, {1'b0, "F"}, {1'b0, "F"}, {1'b0, "F"},
            {1'b0, "F"}, {1'b0, "F"}, {1'b0, "F"}, {1'b0, "0"}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i][7:0], directed_words[i][8]);
        end
        drain_results();

        // Random: mostly well-formed bodies, some broken ones and plain noise
        directed_total = words_sent;
        next_drain     = words_sent + DRAIN_EVERY;
        while (words_sent < directed_total + RAND_WORDS) begin
            burst_mode = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                add_body();
            end else if (pick < 85) begin
                add_body();
                idx = $urandom_range(0, body_q.size() - 1);
                body_q[idx] = 8'($urandom_range(0, 255));
            end else if (pick < 90) begin
                add_oversize();
            end else begin
                repeat ($urandom_range(4, 20)) body_q.push_back(8'($urandom_range(0, 255)));
            end
            send_body();
            if (words_sent >= next_drain) begin
                drain_results();
                next_drain = words_sent + DRAIN_EVERY;
            end
        end
        burst_mode = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%t: %0d expected results never arrived", $realtime, sb.pending());
            sb.errors++;
        end
        $display("Run: %0d words in (%0d restarts), %0d bodies, %0d mismatches",
                 sb.words_in, sb.restarts, bodies, sb.errors);
        $display("Results: framing %0d, payload %0d, body done %0d, malformed %0d",
                 sb.kind_cnt[KIND_FRAME], sb.kind_cnt[KIND_PAYLOAD],
                 sb.kind_cnt[KIND_DONE], sb.kind_cnt[KIND_BAD]);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
